>>> rtl/hid_remote_report_decoder_defines.svh
// Assertion macros shared by the HID remote report decoder RTL.
// Needs nothing else; taken in by the modules that carry assertions.
`ifndef HID_REMOTE_REPORT_DECODER_DEFINES_SVH
`define HID_REMOTE_REPORT_DECODER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define HRD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define HRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/hrd_pkg.sv
// Package for the HID remote report decoder: codes, key table, report descriptor.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package hrd_pkg;

	// Button codes
	localparam int          KEY_COUNT       = 29;
	localparam logic [4:0]  BTN_MOUSE_LEFT  = 5'd29;
	localparam logic [4:0]  BTN_MOUSE_RIGHT = 5'd30;
	localparam logic [4:0]  BTN_UNKNOWN     = 5'd31;

	// Report IDs of the key report forms
	localparam logic [7:0]  ID_KEYBOARD = 8'h01;
	localparam logic [7:0]  ID_CONSUMER = 8'h04;
	localparam logic [7:0]  ID_SYSTEM   = 8'h05;

	// Position of the final byte for each known report length
	localparam logic [3:0]  LAST_POS_MOUSE    = 4'd3;
	localparam logic [3:0]  LAST_POS_KEYBOARD = 4'd7;
	localparam logic [3:0]  LAST_POS_CONSUMER = 4'd2;
	localparam logic [3:0]  LAST_POS_SYSTEM   = 4'd1;
	localparam logic [3:0]  POS_MAX           = 4'd15;

	// Queue depth between front and back
	localparam int          QUEUE_DEPTH = 2;

	// Key table, in button-code order
	localparam logic [7:0] KEY_ID [KEY_COUNT] = '{
		8'h05, 8'h04, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h04,
		8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h01, 8'h01, 8'h01,
		8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01
	};
	localparam logic [15:0] KEY_CODE [KEY_COUNT] = '{
		16'h0001, 16'h00E2, 16'h004B, 16'h004E, 16'h0050, 16'h0051, 16'h0052,
		16'h004F, 16'h0028, 16'h0024, 16'h0023, 16'h00EA, 16'h00CF, 16'h00E9,
		16'h00B6, 16'h00CD, 16'h00B5, 16'h001E, 16'h001F, 16'h0020, 16'h0021,
		16'h0022, 16'h0023, 16'h0024, 16'h0025, 16'h0026, 16'h0027, 16'h002A,
		16'h0065
	};

	// Kind of a finished report
	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_MOUSE,
		KIND_KEY
	} rpt_kind_t;

	// One finished report, as handed from front to back
	typedef struct packed {
		rpt_kind_t   kind;
		logic [7:0]  mask;
		logic [7:0]  mouse_x;
		logic [7:0]  mouse_y;
		logic [7:0]  id;
		logic [15:0] code;
	} hrd_desc_t;

	// Queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} hrd_qstat_t;

	// Table match; first matching entry wins
	function automatic logic [4:0] key_lookup(input logic [7:0] id, input logic [15:0] code);
		logic [4:0] res;
		res = BTN_UNKNOWN;
		for (int i = KEY_COUNT - 1; i >= 0; i--) begin
			if (KEY_ID[i] == id && KEY_CODE[i] == code) begin
				res = 5'(i);
			end
		end
		return res;
	endfunction

endpackage

>>> rtl/hrd_front.sv
// Front end: takes report bytes, gathers per-report fields and classifies each report.
// Depends on hrd_pkg; pushes one descriptor into the queue per final byte.
`timescale 1ns / 1ps
`include "hid_remote_report_decoder_defines.svh"

module hrd_front
	import hrd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  hrd_qstat_t qstat,
	output logic       push,
	output hrd_desc_t  push_desc
);

	logic [3:0]  byte_count_q;
	logic [7:0]  first_q, mask_q, x_q, y_q;
	logic [1:0]  nz_count_q;
	logic [15:0] acc_q;
	logic        too_many_q;

	logic [7:0]  first_d, mask_d, x_d, y_d;
	logic [1:0]  nz_count_d;
	logic [15:0] acc_d;
	logic        too_many_d;
	logic        accept, key_form;

	assign in_ready = !qstat.full;
	assign accept   = in_valid && in_ready;

	// Fold the current word into the report fields
	always_comb begin
		first_d    = first_q;
		mask_d     = mask_q;
		x_d        = x_q;
		y_d        = y_q;
		nz_count_d = nz_count_q;
		acc_d      = acc_q;
		too_many_d = too_many_q;
		if (byte_count_q == 4'd0) begin
			first_d = in_byte;
			mask_d  = in_byte;
		end else begin
			if (byte_count_q == 4'd1) x_d = in_byte;
			if (byte_count_q == 4'd2) y_d = in_byte;
			if (in_byte != 8'd0) begin
				if (nz_count_q == 2'd0) begin
					acc_d[7:0] = in_byte;
					nz_count_d = 2'd1;
				end else if (nz_count_q == 2'd1) begin
					acc_d[15:8] = in_byte;
					nz_count_d  = 2'd2;
				end else begin
					too_many_d = 1'b1;
				end
			end
		end
	end

	// Classify on the final word
	always_comb begin
		key_form = (byte_count_q == LAST_POS_KEYBOARD && first_d == ID_KEYBOARD) ||
			(byte_count_q == LAST_POS_CONSUMER && first_d == ID_CONSUMER) ||
			(byte_count_q == LAST_POS_SYSTEM && first_d == ID_SYSTEM);
		push_desc.mask    = mask_d;
		push_desc.mouse_x = x_d;
		push_desc.mouse_y = y_d;
		push_desc.id      = first_d;
		push_desc.code    = acc_d;
		if (byte_count_q == LAST_POS_MOUSE) begin
			push_desc.kind = KIND_MOUSE;
		end else if (key_form && !too_many_d) begin
			push_desc.kind = KIND_KEY;
		end else begin
			push_desc.kind = KIND_NONE;
		end
	end

	assign push = accept && in_last;

	// Per-report state, cleared after each final word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			first_q      <= '0;
			mask_q       <= '0;
			x_q          <= '0;
			y_q          <= '0;
			nz_count_q   <= '0;
			acc_q        <= '0;
			too_many_q   <= 1'b0;
		end else if (accept) begin
			if (in_last) begin
				byte_count_q <= '0;
				first_q      <= '0;
				mask_q       <= '0;
				x_q          <= '0;
				y_q          <= '0;
				nz_count_q   <= '0;
				acc_q        <= '0;
				too_many_q   <= 1'b0;
			end else begin
				if (byte_count_q != POS_MAX) byte_count_q <= byte_count_q + 4'd1;
				first_q    <= first_d;
				mask_q     <= mask_d;
				x_q        <= x_d;
				y_q        <= y_d;
				nz_count_q <= nz_count_d;
				acc_q      <= acc_d;
				too_many_q <= too_many_d;
			end
		end
	end

	`HRD_ASSERT_NEXT(a_front_clear, clk, arst_n, push, byte_count_q == 4'd0 && nz_count_q == 2'd0, "report state not cleared after final word")
	`HRD_ASSERT_NOW(a_front_nz, clk, arst_n, too_many_q, nz_count_q == 2'd2, "overflow flag set with fewer than two key bytes")

endmodule

>>> rtl/hrd_fifo.sv
// Short descriptor queue between the front and back ends.
// Depends on hrd_pkg for the descriptor and status types.
`timescale 1ns / 1ps
`include "hid_remote_report_decoder_defines.svh"

module hrd_fifo
	import hrd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  hrd_desc_t  push_desc,
	input  logic       pop,
	output hrd_desc_t  pop_desc,
	output hrd_qstat_t qstat
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	hrd_desc_t       mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [PW:0]     count_q;

	assign qstat.full  = (count_q == (PW + 1)'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign pop_desc    = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_desc;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PW'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + PW'(1);
			if (push && !pop) begin
				count_q <= count_q + (PW + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PW + 1)'(1);
			end
		end
	end

	`HRD_ASSERT_NOW(a_fifo_push_full, clk, arst_n, push, !qstat.full || pop, "push into a full queue")
	`HRD_ASSERT_NOW(a_fifo_pop_empty, clk, arst_n, pop, !qstat.empty, "pop from an empty queue")

endmodule

>>> rtl/hrd_back.sv
// Back end: applies each report to the held event state and drives the result word.
// Depends on hrd_pkg for the key table lookup and descriptor type.
`timescale 1ns / 1ps
`include "hid_remote_report_decoder_defines.svh"

module hrd_back
	import hrd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  hrd_qstat_t  qstat,
	input  hrd_desc_t   desc,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [23:0] out_data
);

	logic [4:0] held_button_q, button_d;
	logic       held_pressed_q, pressed_d;
	logic [7:0] held_x_q, held_y_q, x_d, y_d;
	logic       out_valid_q;

	// Output register frees when empty or taken this cycle
	assign pop = !qstat.empty && (!out_valid_q || out_ready);

	// Next held state for the descriptor at the head
	always_comb begin
		button_d  = held_button_q;
		pressed_d = held_pressed_q;
		x_d       = held_x_q;
		y_d       = held_y_q;
		case (desc.kind)
			KIND_MOUSE: begin
				x_d       = desc.mouse_x;
				y_d       = desc.mouse_y;
				pressed_d = (desc.mask != 8'd0);
				if (desc.mask[0]) begin
					button_d = BTN_MOUSE_LEFT;
				end else if (desc.mask[1]) begin
					button_d = BTN_MOUSE_RIGHT;
				end
			end
			KIND_KEY: begin
				pressed_d = (desc.code != 16'd0);
				if (desc.code != 16'd0) button_d = key_lookup(desc.id, desc.code);
			end
			default: begin
			end
		endcase
	end

	// Held state doubles as the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_button_q  <= BTN_UNKNOWN;
			held_pressed_q <= 1'b0;
			held_x_q       <= '0;
			held_y_q       <= '0;
			out_valid_q    <= 1'b0;
		end else if (pop) begin
			held_button_q  <= button_d;
			held_pressed_q <= pressed_d;
			held_x_q       <= x_d;
			held_y_q       <= y_d;
			out_valid_q    <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {2'b00, held_y_q, held_x_q, held_pressed_q, held_button_q};

	`HRD_ASSERT_NEXT(a_back_mouse, clk, arst_n, pop && desc.kind == KIND_MOUSE, held_x_q == $past(desc.mouse_x) && held_y_q == $past(desc.mouse_y), "mouse movement not taken into held state")

endmodule

>>> rtl/hid_remote_report_decoder.sv
// Top level of the HID remote report decoder: front end, descriptor queue, back end.
// Depends on hrd_pkg, hrd_front, hrd_fifo and hrd_back.
//
//  channel  | dir | handshake                      | payload
//  ---------+-----+--------------------------------+------------------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready  | tdata = report_byte, tlast = last_byte
//  m_axis   | out | m_axis_tvalid / m_axis_tready  | tdata = button, pressed, x, y
//
// One report word is taken per cycle; the final word of a report gives one result word,
// registered in the queue and then in the back end (front classifies, queue, back applies
// the table and updates state). The front stalls only when the two-entry descriptor queue
// is full, which happens only while the output word sits untaken. arst_n clears all report
// and held state at once; the held button resets to the unknown code.
`timescale 1ns / 1ps

module hid_remote_report_decoder
	import hrd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] report_byte
	input  logic        s_axis_tlast,   // last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata    // [4:0] button, [5] pressed, [13:6] mouse_x,
	                                    // [21:14] mouse_y, [23:22] zero
);

	hrd_qstat_t qstat;
	hrd_desc_t  push_desc, pop_desc;
	logic       push, pop;

	hrd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.qstat     (qstat),
		.push      (push),
		.push_desc (push_desc)
	);

	hrd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.pop_desc  (pop_desc),
		.qstat     (qstat)
	);

	hrd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.desc      (pop_desc),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule
